### hdl/aod_pkg.sv
`default_nettype none
package aod_pkg;
	localparam int SampleBitsDef = 16;
	localparam int RuleCountDef = 4;
	localparam int CordicSteps = 16;
	localparam int AngW = 32;
	localparam logic [13:0] RuleReset [4] = '{14'd5200, 14'd6470, 14'd7745, 14'd11580};
	localparam logic [2:0] CfgFixed = 3'd0;
	localparam logic [2:0] CfgDefault = 3'd1;
	localparam logic [2:0] CfgRule0 = 3'd2;
	localparam logic signed [AngW-1:0] Deg45 = 32'sd2949120;
	localparam logic signed [AngW-1:0] Deg90 = 32'sd5898240;
	localparam logic signed [AngW-1:0] Deg180 = 32'sd11796480;
	localparam logic signed [AngW-1:0] Deg360 = 32'sd23592960;
	localparam logic [16:0] CordicGain = 17'd107922;

	function automatic logic signed [AngW-1:0] atan_lut(input logic [3:0] i);
		logic signed [AngW-1:0] r;
		unique case (i)
			4'd0: r = 32'sd2949120;
			4'd1: r = 32'sd1740967;
			4'd2: r = 32'sd919879;
			4'd3: r = 32'sd466945;
			4'd4: r = 32'sd234379;
			4'd5: r = 32'sd117304;
			4'd6: r = 32'sd58666;
			4'd7: r = 32'sd29335;
			4'd8: r = 32'sd14668;
			4'd9: r = 32'sd7334;
			4'd10: r = 32'sd3667;
			4'd11: r = 32'sd1833;
			4'd12: r = 32'sd917;
			4'd13: r = 32'sd458;
			4'd14: r = 32'sd229;
			default: r = 32'sd115;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] sector(input logic signed [10:0] th, input logic signed [10:0] a);
		logic [2:0] r;
		if ((th >= 11'sd360 - a && th <= 11'sd359) || (th >= 11'sd0 && th <= a)) r = 3'd1;
		else if (th >= a && th <= 11'sd180 - a) r = 3'd2;
		else if (th >= 11'sd180 - a && th <= 11'sd180 + a) r = 3'd3;
		else if (th >= 11'sd180 + a && th <= 11'sd360 - a) r = 3'd4;
		else r = 3'd0;
		return r;
	endfunction
endpackage
`default_nettype wire

### hdl/accel_orientation_detector_top.sv
// Data path from start to done: heading chain 16, elevation chain 16, 4 glue stages.
// Throughput: one sample per cycle; each stage of both CORDIC cell chains is one register.
// done pulses for one cycle per accepted sample; the receiver cannot stall.
// Reset (arst_n low) clears the valid pipeline and restores configuration defaults.
`default_nettype none
module accel_orientation_detector_top #(
	parameter int SAMPLE_BITS = aod_pkg::SampleBitsDef,
	parameter int RULE_COUNT = aod_pkg::RuleCountDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [SAMPLE_BITS-1:0] accel_x,
	input wire logic signed [SAMPLE_BITS-1:0] accel_y,
	input wire logic signed [SAMPLE_BITS-1:0] accel_z,
	input wire logic [2:0] previous_orientation,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [13:0] cfg_data,
	output logic done,
	output logic [2:0] orientation,
	output logic changed,
	output logic [8:0] heading_degrees,
	output logic [6:0] tilt_degrees
);
	import aod_pkg::*;
	localparam int VW = SAMPLE_BITS + 8 + 4;
	localparam int SW = 3 * SAMPLE_BITS + 3 + 4;
	localparam int Lat = 2 * CordicSteps + 4;
	localparam int GainW = SAMPLE_BITS + 8 + 17;

	logic fixed_q;
	logic [2:0] dflt_q;
	logic [13:0] rule_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q <= 1'b0;
			dflt_q <= 3'd0;
			for (int i = 0; i < 4; i++) rule_q[i] <= RuleReset[i];
		end else if (cfg_we) begin
			if (cfg_index == CfgFixed) fixed_q <= cfg_data[0];
			else if (cfg_index == CfgDefault) dflt_q <= cfg_data[2:0];
			else if (cfg_index >= CfgRule0 && cfg_index <= CfgRule0 + 3'd3)
				rule_q[2'(cfg_index - CfgRule0)] <= cfg_data;
		end
	end

	assign busy = 1'b0;
	logic [Lat-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Lat-2:0], start};
	end

	// stage 1: fold and scale
	logic signed [VW-1:0] hx_s1, hy_s1;
	logic [SW-1:0] side_s1;
	logic signed [VW-1:0] gx, gy;
	assign gx = VW'(accel_y) <<< 8;
	assign gy = VW'(accel_x) <<< 8;
	always_ff @(posedge clk) begin
		hx_s1 <= accel_y[SAMPLE_BITS-1] ? -gx : gx;
		hy_s1 <= accel_y[SAMPLE_BITS-1] ? -gy : gy;
		side_s1 <= {accel_x, accel_y, accel_z, previous_orientation, 4'd0};
	end

	logic signed [VW-1:0] hmag;
	logic signed [AngW-1:0] hang;
	logic [SW-1:0] side_h;
	aod_cordic_chain #(.VW(VW), .SW(SW)) u_head (
		.clk(clk), .x_in(hx_s1), .y_in(hy_s1), .side_in(side_s1),
		.x_out(hmag), .z_out(hang), .side_out(side_h)
	);

	logic signed [SAMPLE_BITS-1:0] hxs, hys, hzs;
	assign hxs = side_h[SW-1 -: SAMPLE_BITS];
	assign hys = side_h[SW-1-SAMPLE_BITS -: SAMPLE_BITS];
	assign hzs = side_h[SW-1-2*SAMPLE_BITS -: SAMPLE_BITS];
	logic signed [2*SAMPLE_BITS-1:0] hxw, hyw, hzw;
	assign hxw = (2*SAMPLE_BITS)'(hxs);
	assign hyw = (2*SAMPLE_BITS)'(hys);
	assign hzw = (2*SAMPLE_BITS)'(hzs);
	logic signed [SAMPLE_BITS:0] fx, fy;
	assign fy = hys[SAMPLE_BITS-1] ? -(SAMPLE_BITS+1)'(hys) : (SAMPLE_BITS+1)'(hys);
	assign fx = hys[SAMPLE_BITS-1] ? -(SAMPLE_BITS+1)'(hxs) : (SAMPLE_BITS+1)'(hxs);
	logic signed [AngW-1:0] exact_ang, tot;
	always_comb begin
		if (fx == 0) exact_ang = '0;
		else if (fy == 0) exact_ang = fx > 0 ? Deg90 : -Deg90;
		else if (fx == fy) exact_ang = Deg45;
		else if (fx == -fy) exact_ang = -Deg45;
		else exact_ang = hang;
		tot = exact_ang + (hys[SAMPLE_BITS-1] ? Deg180 : 32'sd0);
		if (tot < 0) tot = tot + Deg360;
		if (tot >= Deg360) tot = tot - Deg360;
	end

	// stage 2: heading, gain multiply for elevation
	logic [8:0] head_s2;
	logic signed [VW-1:0] ex_s2;
	logic [SAMPLE_BITS-1:0] az_s2;
	logic [SW-1:0] side_s2;
	logic [2*SAMPLE_BITS:0] r2_s2, z2_s2;
	always_ff @(posedge clk) begin
		head_s2 <= 9'(tot >>> 16);
		ex_s2 <= hmag;
		az_s2 <= hzs[SAMPLE_BITS-1] ? SAMPLE_BITS'(-hzs) : SAMPLE_BITS'(hzs);
		side_s2 <= side_h;
		r2_s2 <= (2*SAMPLE_BITS+1)'(hxw * hxw) + (2*SAMPLE_BITS+1)'(hyw * hyw);
		z2_s2 <= (2*SAMPLE_BITS+1)'(hzw * hzw);
	end
	logic [GainW-1:0] eprod;
	assign eprod = GainW'({az_s2, 8'd0}) * GainW'(CordicGain);
	logic signed [VW-1:0] ey_s3, ex_s3;
	logic [SW-1:0] side_s3;
	always_ff @(posedge clk) begin
		ey_s3 <= VW'(eprod >> 16);
		ex_s3 <= ex_s2;
		side_s3 <= {side_s2[SW-1:4], 1'b0, (r2_s2 == z2_s2), 2'b00};
	end

	logic [8:0] head_s2q;
	always_ff @(posedge clk) head_s2q <= head_s2;
	logic signed [VW-1:0] emag;
	logic signed [AngW-1:0] eang;
	logic [SW-1:0] side_e;
	logic [8:0] head_e;
	aod_cordic_chain #(.VW(VW), .SW(SW + 9)) u_elev (
		.clk(clk), .x_in(ex_s3), .y_in(ey_s3), .side_in({side_s3, head_s2q}),
		.x_out(emag), .z_out(eang), .side_out({side_e, head_e})
	);

	logic signed [SAMPLE_BITS-1:0] exs, eys, ezs;
	logic [2:0] eprev;
	assign exs = side_e[SW-1 -: SAMPLE_BITS];
	assign eys = side_e[SW-1-SAMPLE_BITS -: SAMPLE_BITS];
	assign ezs = side_e[SW-1-2*SAMPLE_BITS -: SAMPLE_BITS];
	assign eprev = side_e[6:4];
	logic [6:0] elev;
	always_comb begin
		if (ezs == 0) elev = 7'd0;
		else if (exs == 0 && eys == 0) elev = 7'd90;
		else if (side_e[2]) elev = 7'd45;
		else if (eang < 0) elev = 7'd0;
		else if ((eang >>> 16) > 90) elev = 7'd90;
		else elev = 7'(eang >>> 16);
	end

	// final stage: rules and decision
	logic [2:0] newrot, dflt, ori;
	logic chg;
	logic signed [10:0] ang;
	logic [6:0] tl;
	always_comb begin
		tl = 7'd90 - elev;
		newrot = 3'd0;
		ang = '0;
		if (!(exs == 0 && eys == 0 && ezs == 0)) begin
			for (int i = RULE_COUNT - 1; i >= 0; i--) begin
				if (tl >= 7'd30 && tl <= rule_q[i][13:7]) begin
					ang = 11'(rule_q[i][6:0]);
					if (!(eprev == 3'd1 || eprev == 3'd3)) ang = 11'sd90 - ang;
					newrot = sector(11'(head_e), ang);
				end
			end
		end
		dflt = dflt_q <= 3'd3 ? dflt_q + 3'd1 : 3'd0;
		ori = 3'd0;
		chg = 1'b0;
		if (fixed_q) begin
			ori = dflt;
			chg = eprev == 3'd0;
		end else if (newrot == 3'd0) begin
			if (eprev == 3'd0) begin
				ori = dflt != 3'd0 ? dflt : 3'd1;
				chg = 1'b1;
			end
		end else if (newrot != eprev) begin
			ori = newrot;
			chg = 1'b1;
		end
		if (!chg) ori = 3'd0;
	end
	always_ff @(posedge clk) begin
		orientation <= ori;
		changed <= chg;
		heading_degrees <= head_e;
		tilt_degrees <= tl;
	end
	assign done = vld_q[Lat-1];
endmodule
`default_nettype wire

### hdl/aod_cordic_cell.sv
`default_nettype none
module aod_cordic_cell #(
	parameter int VW = 48,
	parameter int SHIFT = 0
) (
	input wire logic clk,
	input wire logic signed [VW-1:0] x_in,
	input wire logic signed [VW-1:0] y_in,
	input wire logic signed [aod_pkg::AngW-1:0] z_in,
	output logic signed [VW-1:0] x_out,
	output logic signed [VW-1:0] y_out,
	output logic signed [aod_pkg::AngW-1:0] z_out
);
	import aod_pkg::*;
	localparam logic signed [AngW-1:0] Atan = atan_lut(4'(SHIFT));
	logic signed [VW-1:0] dx, dy;
	// truncate toward zero
	assign dx = (y_in < 0) ? -((-y_in) >>> SHIFT) : (y_in >>> SHIFT);
	assign dy = (x_in < 0) ? -((-x_in) >>> SHIFT) : (x_in >>> SHIFT);
	always_ff @(posedge clk) begin
		if (y_in >= 0) begin
			x_out <= x_in + dx;
			y_out <= y_in - dy;
			z_out <= z_in + Atan;
		end else begin
			x_out <= x_in - dx;
			y_out <= y_in + dy;
			z_out <= z_in - Atan;
		end
	end
endmodule
`default_nettype wire

### hdl/aod_cordic_chain.sv
`default_nettype none
module aod_cordic_chain #(
	parameter int VW = 48,
	parameter int SW = 8
) (
	input wire logic clk,
	input wire logic signed [VW-1:0] x_in,
	input wire logic signed [VW-1:0] y_in,
	input wire logic [SW-1:0] side_in,
	output logic signed [VW-1:0] x_out,
	output logic signed [aod_pkg::AngW-1:0] z_out,
	output logic [SW-1:0] side_out
);
	import aod_pkg::*;
	logic signed [VW-1:0] xs [CordicSteps+1];
	logic signed [VW-1:0] ys [CordicSteps+1];
	logic signed [AngW-1:0] zs [CordicSteps+1];
	logic [SW-1:0] sd [CordicSteps+1];
	assign xs[0] = x_in;
	assign ys[0] = y_in;
	assign zs[0] = '0;
	assign sd[0] = side_in;
	for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
		aod_cordic_cell #(.VW(VW), .SHIFT(i)) u_cell (
			.clk(clk), .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
			.x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1])
		);
		always_ff @(posedge clk) sd[i+1] <= sd[i];
	end
	assign x_out = xs[CordicSteps];
	assign z_out = zs[CordicSteps];
	assign side_out = sd[CordicSteps];
endmodule
`default_nettype wire

### hdl/aod_checker.sv
`default_nettype none
module aod_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic done,
	input wire logic busy,
	input wire logic changed,
	input wire logic [2:0] orientation,
	input wire logic [8:0] heading_degrees,
	input wire logic [6:0] tilt_degrees
);
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> heading_degrees <= 9'd359) else $error("heading range");
	a_tilt: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> tilt_degrees <= 7'd90) else $error("tilt range");
	a_nc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !changed) |-> orientation == 3'd0) else $error("orientation when unchanged");
	a_ori: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> orientation <= 3'd4) else $error("orientation code");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");
endmodule
bind accel_orientation_detector_top aod_checker u_aod_checker (.*);
`default_nettype wire
